>>> hdl/mavg_pkg.sv
// shared types and constants of the moving average filter
package mavg_pkg;

  // default parameter values
  localparam int WINDOW_MAX_DEFAULT    = 64;
  localparam int FRACTION_BITS_DEFAULT = 8;

  // fixed field widths
  localparam int SAMPLE_W    = 16;
  localparam int AVG_W       = 24;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int SIZE_W      = 7;

  // register reset values
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd8;

  // saturation bounds of the average, as magnitudes
  localparam logic [AVG_W-1:0] AVG_POS_MAX = 24'h7F_FFFF;
  localparam logic [AVG_W-1:0] AVG_NEG_MAX = 24'h80_0000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_SIZE   = 1'b0,
    REG_WEIGHTED_MODE = 1'b1
  } cfg_reg_t;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // control shared by every window cell
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> hdl/moving_average_filter.sv
// moving average filter top level: window cell chain, running sums, divider, output register
//
// Each sample pushes into a chain of window cells and returns the mean of the last N samples,
// plain or linearly weighted (newest weight N), as signed Q.FRACTION_BITS truncated toward zero
// and saturated to 24 bits. The running sums are updated in the cycle the sample is taken; the
// quotient then comes from a one-bit-per-cycle serial divider. The result is loaded into the
// output register from the finish state after the divider has run over all WW + FRACTION_BITS
// dividend bits, where WW is the weighted sum width (29 with a 64 deep window); the next sample
// can be taken in the cycle after that load, not before. A stalled receiver adds its stall once
// a finished result finds the output register still full. A new sample is taken while the last
// result still waits in the output register. Writing either register clears the window and both
// sums at once; register index 0 is window_size (1..WINDOW_MAX, 0 acts as 1, larger values
// saturate), index 1 is weighted_mode.
module moving_average_filter #(
  parameter int WINDOW_MAX    = mavg_pkg::WINDOW_MAX_DEFAULT,
  parameter int FRACTION_BITS = mavg_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // sample stream; tdata: sample[15:0]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mavg_pkg::SAMPLE_W-1:0]     s_tdata,
  // average stream; tdata: average[23:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mavg_pkg::AVG_W-1:0]        m_tdata,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mavg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mavg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int N_W      = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W    = (N_W > mavg_pkg::SIZE_W) ? N_W : mavg_pkg::SIZE_W;
  localparam int WSUM_MAX = WINDOW_MAX * (WINDOW_MAX + 1) / 2;
  localparam int PW       = mavg_pkg::SAMPLE_W + 1 + N_W;
  localparam int WW       = mavg_pkg::SAMPLE_W + 1 + $clog2(WSUM_MAX + 1);
  localparam int PROD_W   = mavg_pkg::SAMPLE_W + 1 + N_W;
  localparam int DVS_W    = $clog2(WSUM_MAX + 1);
  localparam int DVD_W    = WW + FRACTION_BITS;
  localparam int QW       = (DVD_W > mavg_pkg::AVG_W) ? DVD_W : mavg_pkg::AVG_W;

  // configuration registers
  logic [mavg_pkg::SIZE_W-1:0] window_size;
  logic                        weighted_mode;
  logic                        cfg_fire;
  logic                        cfg_clear;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= mavg_pkg::SIZE_RESET;
      weighted_mode <= 1'b0;
    end else if (cfg_fire) begin
      unique case (mavg_pkg::cfg_reg_t'(cfg_index))
        mavg_pkg::REG_WINDOW_SIZE:   window_size   <= mavg_pkg::SIZE_W'(cfg_data);
        mavg_pkg::REG_WEIGHTED_MODE: weighted_mode <= cfg_data[0];
      endcase
    end
  end

  // any write of a listed register clears the window
  always_comb begin
    unique case (mavg_pkg::cfg_reg_t'(cfg_index))
      mavg_pkg::REG_WINDOW_SIZE:   cfg_clear = cfg_fire;
      mavg_pkg::REG_WEIGHTED_MODE: cfg_clear = cfg_fire;
    endcase
  end

  // effective window length
  logic [N_W-1:0] n_eff;

  always_comb begin
    if (window_size == '0) begin
      n_eff = N_W'(1);
    end else if (CMP_W'(window_size) > CMP_W'(WINDOW_MAX)) begin
      n_eff = N_W'(WINDOW_MAX);
    end else begin
      n_eff = N_W'(window_size);
    end
  end

  // sequencer
  mavg_pkg::state_t      state;
  mavg_pkg::state_t      state_next;
  mavg_pkg::div_status_t div_status;
  logic                  s_fire;
  logic                  div_start;
  logic                  out_load;

  assign s_fire = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      mavg_pkg::ST_IDLE:   if (s_fire) state_next = mavg_pkg::ST_START;
      mavg_pkg::ST_START:  state_next = mavg_pkg::ST_DIVIDE;
      mavg_pkg::ST_DIVIDE: if (div_status.done) state_next = mavg_pkg::ST_FINISH;
      mavg_pkg::ST_FINISH: if (out_load) state_next = mavg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == mavg_pkg::ST_IDLE);
    div_start = (state == mavg_pkg::ST_START);
    out_load  = (state == mavg_pkg::ST_FINISH) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mavg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window cell chain: cell 0 oldest, cell n-1 newest
  mavg_pkg::sample_t  sample_in;
  mavg_pkg::sample_t  cell_value [WINDOW_MAX];
  mavg_pkg::cell_ctrl_t cell_ctrl;

  assign sample_in       = $signed(s_tdata);
  assign cell_ctrl.clear = cfg_clear;
  assign cell_ctrl.shift = s_fire;

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    mavg_pkg::sample_t neighbor;
    if (k == WINDOW_MAX - 1) begin : g_end
      assign neighbor = '0;
    end else begin : g_inner
      assign neighbor = cell_value[k+1];
    end
    mavg_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cell_ctrl),
      .tail     (n_eff == N_W'(k + 1)),
      .active   (N_W'(k + 1) < n_eff),
      .sample   (sample_in),
      .neighbor (neighbor),
      .value    (cell_value[k])
    );
  end

  // running sums: the oldest sample leaves, the weights step down by one
  logic signed [PW-1:0]     plain_sum;
  logic signed [WW-1:0]     weighted_sum;
  logic signed [PW-1:0]     plain_sum_next;
  logic signed [WW-1:0]     weighted_sum_next;
  logic signed [PROD_W-1:0] weight_prod;

  assign weight_prod = PROD_W'(sample_in) * PROD_W'($signed({1'b0, n_eff}));

  always_comb begin
    plain_sum_next    = plain_sum + PW'(sample_in) - PW'(cell_value[0]);
    weighted_sum_next = weighted_sum - WW'(plain_sum) + WW'(weight_prod);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      plain_sum    <= '0;
      weighted_sum <= '0;
    end else if (s_fire) begin
      plain_sum    <= plain_sum_next;
      weighted_sum <= weighted_sum_next;
    end
  end

  // divider operands
  logic signed [WW-1:0] sel_sum;
  logic [WW-1:0]        sum_mag;
  logic [DVD_W-1:0]     dividend;
  logic [2*N_W-1:0]     tri_prod;
  logic [DVS_W-1:0]     divisor;
  logic                 result_neg;

  always_comb begin
    sel_sum  = weighted_mode ? weighted_sum : WW'(plain_sum);
    sum_mag  = sel_sum[WW-1] ? WW'(-sel_sum) : WW'(sel_sum);
    dividend = DVD_W'(sum_mag) << FRACTION_BITS;
    tri_prod = (2*N_W)'(n_eff) * (2*N_W)'(n_eff + 1'b1);
    divisor  = weighted_mode ? DVS_W'(tri_prod >> 1) : DVS_W'(n_eff);
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      result_neg <= sel_sum[WW-1];
    end
  end

  logic [DVD_W-1:0] quotient;

  mavg_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .status   (div_status)
  );

  // saturate and apply the sign
  logic [QW-1:0]                quo_ext;
  logic [mavg_pkg::AVG_W-1:0]   quo_sat;
  logic [mavg_pkg::AVG_W-1:0]   average;

  always_comb begin
    quo_ext = QW'(quotient);
    if (result_neg) begin
      quo_sat = (quo_ext > QW'(mavg_pkg::AVG_NEG_MAX)) ? mavg_pkg::AVG_NEG_MAX
                                                       : mavg_pkg::AVG_W'(quo_ext);
      average = mavg_pkg::AVG_W'(0) - quo_sat;
    end else begin
      quo_sat = (quo_ext > QW'(mavg_pkg::AVG_POS_MAX)) ? mavg_pkg::AVG_POS_MAX
                                                       : mavg_pkg::AVG_W'(quo_ext);
      average = quo_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= average;
    end
  end

  // checks
  a_start_busy : assert property (@(posedge clk) disable iff (rst)
    state == mavg_pkg::ST_START |=> div_status.busy)
    else $error("divider not busy after start");

  a_idle_free : assert property (@(posedge clk) disable iff (rst)
    state == mavg_pkg::ST_IDLE |-> !div_status.busy)
    else $error("divider busy while sequencer idle");

  a_cfg_clears : assert property (@(posedge clk) disable iff (rst)
    cfg_clear |=> plain_sum == '0 && weighted_sum == '0)
    else $error("register write did not clear sums");

  a_unit_window : assert property (@(posedge clk) disable iff (rst)
    n_eff == N_W'(1) && $stable(n_eff) |-> weighted_sum == WW'(plain_sum))
    else $error("weighted and plain sums differ for a one-sample window");

endmodule

>>> hdl/mavg_cell.sv
// one window cell: holds a sample and on a shift takes the new sample (tail) or its neighbor's (active)
module mavg_cell (
  input  logic                clk,
  input  logic                rst,
  input  mavg_pkg::cell_ctrl_t ctrl,
  input  logic                tail,
  input  logic                active,
  input  mavg_pkg::sample_t   sample,
  input  mavg_pkg::sample_t   neighbor,
  output mavg_pkg::sample_t   value
);

  mavg_pkg::sample_t value_next;

  // tail cell takes the new sample, inner cells move toward the oldest end
  always_comb begin
    value_next = value;
    if (ctrl.clear) begin
      value_next = '0;
    end else if (ctrl.shift && tail) begin
      value_next = sample;
    end else if (ctrl.shift && active) begin
      value_next = neighbor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else begin
      value <= value_next;
    end
  end

endmodule

>>> hdl/mavg_div.sv
// restoring serial divider, one quotient bit per cycle
module mavg_div #(
  parameter int DVD_W = 37,
  parameter int DVS_W = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [DVD_W-1:0]        dividend,
  input  logic [DVS_W-1:0]        divisor,
  output logic [DVD_W-1:0]        quotient,
  output mavg_pkg::div_status_t   status
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] count;
  logic [DVS_W:0]   rem_shift;
  logic [DVS_W:0]   rem_trial;
  logic             bit_set;

  // trial subtraction of the divisor from the shifted remainder
  always_comb begin
    rem_shift = {rem, quotient[DVD_W-1]};
    rem_trial = rem_shift - {1'b0, dvs};
    bit_set   = (rem_shift >= {1'b0, dvs});
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (status.busy) begin
      quotient <= {quotient[DVD_W-2:0], bit_set};
      rem      <= bit_set ? rem_trial[DVS_W-1:0] : rem_shift[DVS_W-1:0];
    end
  end

  // step counter and status
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      status.busy <= 1'b0;
      status.done <= 1'b0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        count       <= CNT_W'(DVD_W);
        status.busy <= 1'b1;
      end else if (status.busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> test/tb.sv
// testbench of the moving average filter: self-checking stream test with a scoreboard class
module tb;

  localparam int WIN       = mavg_pkg::WINDOW_MAX_DEFAULT;
  localparam int FRAC      = mavg_pkg::FRACTION_BITS_DEFAULT;
  localparam int SW        = mavg_pkg::SAMPLE_W;
  localparam int AW        = mavg_pkg::AVG_W;
  localparam int TARGET    = 1050;
  localparam int HOLD      = 400;
  localparam int LIMIT     = 600000;
  localparam int SETTLE    = 60;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int {MIX_UNIFORM, MIX_EXTREME, MIX_SMALL} mix_t;

  // window history, running configuration and the averages still owed by the block
  class avg_scoreboard;
    logic signed [SW-1:0] hist [WIN];
    int slot;
    int size;
    bit weighted;
    logic [AW-1:0] expected_averages [$];
    int errors;
    int checked;
    int taken;

    function new();
      size = int'(mavg_pkg::SIZE_RESET);
      weighted = 1'b0;
      clear_window();
    endfunction

    function void clear_window();
      foreach (hist[i]) hist[i] = '0;
      slot = 0;
    endfunction

    // any register write empties the window
    function void write_reg(mavg_pkg::cfg_reg_t idx, logic [mavg_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        mavg_pkg::REG_WINDOW_SIZE: begin
          size = int'(d[mavg_pkg::SIZE_W-1:0]);
        end
        mavg_pkg::REG_WEIGHTED_MODE: begin
          weighted = d[0];
        end
        default: begin
        end
      endcase
      clear_window();
    endfunction

    // push one sample and work out the average it must produce
    function void note_sample(logic [SW-1:0] raw);
      int n;
      int pos;
      longint plain;
      longint wsum;
      longint total;
      longint divisor;
      longint mag;
      longint quo;
      bit neg;
      logic [AW-1:0] avg;
      hist[slot] = raw;
      slot = (slot + 1 == WIN) ? 0 : slot + 1;
      n = (size == 0) ? 1 : (size > WIN) ? WIN : size;
      plain = 0;
      wsum = 0;
      pos = slot;
      // newest sample gets weight n, oldest weight 1
      for (int j = 0; j < n; j++) begin
        pos = (pos == 0) ? WIN - 1 : pos - 1;
        plain += longint'(hist[pos]);
        wsum += longint'(hist[pos]) * longint'(n - j);
      end
      total = weighted ? wsum : plain;
      divisor = weighted ? longint'(n) * longint'(n + 1) / 2 : longint'(n);
      // divide the magnitude so the quotient truncates toward zero
      neg = total < 0;
      mag = neg ? -total : total;
      quo = (mag << FRAC) / divisor;
      if (neg) begin
        if (quo > longint'(mavg_pkg::AVG_NEG_MAX)) quo = longint'(mavg_pkg::AVG_NEG_MAX);
        avg = AW'(-quo);
      end else begin
        if (quo > longint'(mavg_pkg::AVG_POS_MAX)) quo = longint'(mavg_pkg::AVG_POS_MAX);
        avg = AW'(quo);
      end
      expected_averages.push_back(avg);
      taken++;
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_average(logic [AW-1:0] got);
      logic [AW-1:0] want;
      if (expected_averages.size() == 0) begin
        report($sformatf("average %h arrived with none outstanding", got));
      end else begin
        want = expected_averages.pop_front();
        checked++;
        if (got !== want)
          report($sformatf("average %0d: got %h, expected %h", checked, got, want));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [SW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [AW-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mavg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mavg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  avg_scoreboard sb;
  idle_mode_t idle_mode = IDLE_NONE;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int cycles = 0;
  int sent = 0;
  int writes = 0;
  logic [SW-1:0] sticky = 16'h7FFF;

  // directed sample lists
  logic [SW-1:0] opening_run [10] = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                                      16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};
  logic [SW-1:0] zero_size_run [3] = '{16'h8000, 16'h7FFF, 16'hFFFF};
  logic [SW-1:0] over_size_run [4] = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF};
  logic [SW-1:0] unit_size_run [3] = '{16'd100, 16'h8000, 16'h7FFF};

  moving_average_filter uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side: check each accepted average, then pick the next ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_average(m_tdata);
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (idle_mode == IDLE_RECEIVER) begin
      m_tready <= ($urandom_range(0, 99) >= 73);
    end else if (idle_mode == IDLE_BOTH) begin
      m_tready <= ($urandom_range(0, 99) >= 35);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // sample source for the random phases
  function automatic logic [SW-1:0] next_sample(mix_t mix);
    case (mix)
      MIX_EXTREME: begin
        if ($urandom_range(0, 15) == 0) sticky = ~sticky;
        if ($urandom_range(0, 9) == 0) return SW'($urandom);
        return sticky;
      end
      MIX_SMALL: begin
        return SW'($urandom_range(0, 8) - 4);
      end
      default: begin
        return SW'($urandom);
      end
    endcase
  endfunction

  // offer one sample, with a random gap first when the sender idles
  task automatic push_sample(logic [SW-1:0] v);
    int gap;
    int pct;
    gap = 0;
    if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
      pct = (idle_mode == IDLE_SENDER) ? 73 : 35;
      if ($urandom_range(0, 7) == 0) gap = $urandom_range(0, 60);
      else while ($urandom_range(0, 99) < pct) gap++;
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(v);
    sent++;
  endtask

  // one register write request; valid stays up for a following write
  task automatic write_reg(mavg_pkg::cfg_reg_t idx, logic [mavg_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    writes++;
  endtask

  task automatic configure(logic [mavg_pkg::SIZE_W-1:0] size_val, logic mode);
    write_reg(mavg_pkg::REG_WINDOW_SIZE, size_val);
    write_reg(mavg_pkg::REG_WEIGHTED_MODE, {6'($urandom), mode});
    cfg_valid <= 1'b0;
  endtask

  // stop offering and wait for every owed average
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_averages.size() != 0) @(posedge clk);
  endtask

  initial begin
    int p;
    int count;
    logic [mavg_pkg::SIZE_W-1:0] sz;
    mix_t mix;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings over more samples than the window holds, then odd sizes: 0 and 127 weighted, 1 plain
    foreach (opening_run[i]) push_sample(opening_run[i]);
    drain();
    configure(7'd0, 1'b1);
    foreach (zero_size_run[i]) push_sample(zero_size_run[i]);
    drain();
    configure(7'd127, 1'b1);
    foreach (over_size_run[i]) push_sample(over_size_run[i]);
    drain();
    configure(7'd1, 1'b0);
    foreach (unit_size_run[i]) push_sample(unit_size_run[i]);
    drain();

    // random phases: size, mode, idling and sample mix change per phase
    p = 0;
    while (sent < TARGET) begin
      case (p % 6)
        0: sz = 7'd1;
        1: sz = mavg_pkg::SIZE_W'(WIN);
        2: sz = 7'd0;
        3: sz = 7'd127;
        4: sz = mavg_pkg::SIZE_W'($urandom_range(2, WIN - 1));
        default: sz = mavg_pkg::SIZE_W'($urandom_range(0, 127));
      endcase
      // the mode flips between the first and second round of sizes
      configure(sz, logic'(((p / 6) + p) & 1));
      idle_mode = idle_mode_t'(p % 4);
      mix = (p % 3 == 1) ? MIX_EXTREME : mix_t'($urandom_range(0, 2));
      // long output hold while samples are still offered
      if (p == 0) hold_req = 1'b1;
      count = 60 + $urandom_range(0, 40);
      if (count > TARGET - sent) count = TARGET - sent;
      repeat (count) push_sample(next_sample(mix));
      drain();
      p++;
    end

    idle_mode = IDLE_NONE;
    repeat (SETTLE) @(posedge clk);
    $display("%0d samples sent, %0d averages checked, %0d register writes, %0d phases",
             sb.taken, sb.checked, writes, p);
    $display("window sizes 0, 1, 64 and 127 in both modes, random stalls and a %0d-cycle hold",
             HOLD);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
